// ===== design/line_point_stepper_macros.svh =====
// assertion macros for the line point stepper checker
// expects clk and rst_n in the scope where they are used
`ifndef LINE_POINT_STEPPER_MACROS_SVH
`define LINE_POINT_STEPPER_MACROS_SVH

// same-cycle implication
`define LPS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("line_point_stepper check failed");

// next-cycle implication
`define LPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line_point_stepper check failed");

`endif

// ===== design/lps_pkg.sv =====
// shared types and constants of the line point stepper
// no dependencies
package lps_pkg;

    localparam int COORD_BITS     = 16;
    localparam int DIM_BITS       = 15;
    localparam int ERR_BITS       = COORD_BITS + 1;
    localparam int CMP_BITS       = (COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS + 1;
    localparam int CFG_INDEX_BITS = 1;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_STEP = 1'b1;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    localparam logic [DIM_BITS-1:0] DIM_RESET = DIM_BITS'(1024);

    typedef struct packed {
        logic                         action;
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
    } cmd_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic                         inside_res;
        logic                         last_point;
    } point_t;

    typedef struct packed {
        logic                         is_load;
        logic                         major_is_y;
        logic                         minor_dec;
        logic signed [COORD_BITS-1:0] cur_x;
        logic signed [COORD_BITS-1:0] cur_y;
        logic signed [COORD_BITS-1:0] major_end;
        logic        [COORD_BITS-1:0] major_delta;
        logic        [COORD_BITS-1:0] minor_delta;
    } entry_t;

    typedef struct packed {
        logic [DIM_BITS-1:0] image_width;
        logic [DIM_BITS-1:0] image_height;
    } cfg_t;

    typedef struct packed {
        logic full;
        logic head_valid;
    } queue_status_t;

endpackage

// ===== design/lps_front.sv =====
// front end: accepts commands, decodes loads into start point, deltas and direction
// depends on lps_pkg
module lps_front (
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  lps_pkg::cmd_t         cmd,
    input  lps_pkg::queue_status_t qstat,
    output logic                  push,
    output lps_pkg::entry_t       entry
);
    import lps_pkg::*;

    logic signed [COORD_BITS:0] dx, dy, ndx, ndy;
    logic [COORD_BITS-1:0]      mag_x, mag_y, minor_mag;
    logic                       y_major, swap, minor_neg;

    assign cmd_ready = !qstat.full;
    assign push      = cmd_valid && cmd_ready;

    always_comb
    begin
        dx  = {cmd.end_x[COORD_BITS-1], cmd.end_x} - {cmd.start_x[COORD_BITS-1], cmd.start_x};
        dy  = {cmd.end_y[COORD_BITS-1], cmd.end_y} - {cmd.start_y[COORD_BITS-1], cmd.start_y};
        ndx = {cmd.start_x[COORD_BITS-1], cmd.start_x} - {cmd.end_x[COORD_BITS-1], cmd.end_x};
        ndy = {cmd.start_y[COORD_BITS-1], cmd.start_y} - {cmd.end_y[COORD_BITS-1], cmd.end_y};

        mag_x = dx[COORD_BITS] ? ndx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
        mag_y = dy[COORD_BITS] ? ndy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];

        y_major   = mag_x < mag_y;
        swap      = y_major ? dy[COORD_BITS] : dx[COORD_BITS];
        minor_neg = y_major ? dx[COORD_BITS] : dy[COORD_BITS];
        minor_mag = y_major ? mag_x : mag_y;

        entry.is_load     = (cmd.action == ACT_LOAD);
        entry.major_is_y  = y_major;
        entry.minor_dec   = (minor_mag != '0) && (minor_neg ^ swap);
        entry.cur_x       = swap ? cmd.end_x : cmd.start_x;
        entry.cur_y       = swap ? cmd.end_y : cmd.start_y;
        entry.major_delta = y_major ? mag_y : mag_x;
        entry.minor_delta = minor_mag;
        if (y_major)
        begin
            entry.major_end = swap ? cmd.start_y : cmd.end_y;
        end
        else
        begin
            entry.major_end = swap ? cmd.start_x : cmd.end_x;
        end
    end

endmodule

// ===== design/lps_queue.sv =====
// short fifo of decoded commands between front and back
// depends on lps_pkg
module lps_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  lps_pkg::entry_t        entry,
    input  logic                   pop,
    output lps_pkg::queue_status_t qstat,
    output lps_pkg::entry_t        head
);
    import lps_pkg::*;

    entry_t               slot_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_BITS:0]   count_reg, count_next;

    assign qstat.full       = (count_reg == (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign qstat.head_valid = (count_reg != '0);
    assign head             = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        priority if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= entry;
        end
    end

endmodule

// ===== design/lps_back.sv =====
// back end: line state, one point per step transaction while a line is drawn, output register
// depends on lps_pkg
module lps_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  lps_pkg::queue_status_t qstat,
    input  lps_pkg::entry_t        head,
    output logic                   pop,
    input  lps_pkg::cfg_t          cfg,
    output logic                   pt_valid,
    input  logic                   pt_ready,
    output lps_pkg::point_t        pt
);
    import lps_pkg::*;

    logic                         drawing_reg, drawing_next;
    logic                         major_is_y_reg, major_is_y_next;
    logic                         minor_dec_reg, minor_dec_next;
    logic signed [COORD_BITS-1:0] cur_x_reg, cur_x_next;
    logic signed [COORD_BITS-1:0] cur_y_reg, cur_y_next;
    logic signed [COORD_BITS-1:0] major_end_reg, major_end_next;
    logic        [COORD_BITS-1:0] major_delta_reg, major_delta_next;
    logic        [COORD_BITS-1:0] minor_delta_reg, minor_delta_next;
    logic        [ERR_BITS-1:0]   err_reg, err_next;
    logic                         out_valid_reg, out_valid_next;
    point_t                       out_reg, out_next;

    logic                         slot_free, emit, last, move, in_image;
    logic signed [COORD_BITS-1:0] majc, minor_step;
    logic        [ERR_BITS-1:0]   err_sum;

    assign slot_free = !out_valid_reg || pt_ready;
    assign emit      = qstat.head_valid && !head.is_load && drawing_reg && slot_free;
    assign pop       = qstat.head_valid && (head.is_load || !drawing_reg || slot_free);
    assign pt_valid  = out_valid_reg;
    assign pt        = out_reg;

    always_comb
    begin
        majc       = major_is_y_reg ? cur_y_reg : cur_x_reg;
        last       = majc >= major_end_reg;
        in_image   = !cur_x_reg[COORD_BITS-1] && !cur_y_reg[COORD_BITS-1]
                  && (CMP_BITS'($unsigned(cur_x_reg)) < CMP_BITS'(cfg.image_width))
                  && (CMP_BITS'($unsigned(cur_y_reg)) < CMP_BITS'(cfg.image_height));
        err_sum    = err_reg + ERR_BITS'(minor_delta_reg);
        move       = err_sum >= ERR_BITS'(major_delta_reg);
        minor_step = minor_dec_reg ? '1 : COORD_BITS'(1);
    end

    always_comb
    begin
        drawing_next     = drawing_reg;
        major_is_y_next  = major_is_y_reg;
        minor_dec_next   = minor_dec_reg;
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        major_end_next   = major_end_reg;
        major_delta_next = major_delta_reg;
        minor_delta_next = minor_delta_reg;
        err_next         = err_reg;
        out_valid_next   = pt_ready ? 1'b0 : out_valid_reg;
        out_next         = out_reg;

        priority if (pop && head.is_load)
        begin
            drawing_next     = 1'b1;
            major_is_y_next  = head.major_is_y;
            minor_dec_next   = head.minor_dec;
            cur_x_next       = head.cur_x;
            cur_y_next       = head.cur_y;
            major_end_next   = head.major_end;
            major_delta_next = head.major_delta;
            minor_delta_next = head.minor_delta;
            err_next         = '0;
        end
        else if (emit)
        begin
            out_valid_next      = 1'b1;
            out_next.point_x    = cur_x_reg;
            out_next.point_y    = cur_y_reg;
            out_next.inside_res = in_image;
            out_next.last_point = last;
            if (last)
            begin
                drawing_next = 1'b0;
            end
            else
            begin
                err_next = move ? err_sum - ERR_BITS'(major_delta_reg) : err_sum;
                if (major_is_y_reg)
                begin
                    cur_y_next = cur_y_reg + COORD_BITS'(1);
                    if (move)
                    begin
                        cur_x_next = cur_x_reg + minor_step;
                    end
                end
                else
                begin
                    cur_x_next = cur_x_reg + COORD_BITS'(1);
                    if (move)
                    begin
                        cur_y_next = cur_y_reg + minor_step;
                    end
                end
            end
        end
        else
        begin
            out_next = out_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drawing_reg     <= 1'b0;
            major_is_y_reg  <= 1'b0;
            minor_dec_reg   <= 1'b0;
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            major_end_reg   <= '0;
            major_delta_reg <= '0;
            minor_delta_reg <= '0;
            err_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            drawing_reg     <= drawing_next;
            major_is_y_reg  <= major_is_y_next;
            minor_dec_reg   <= minor_dec_next;
            cur_x_reg       <= cur_x_next;
            cur_y_reg       <= cur_y_next;
            major_end_reg   <= major_end_next;
            major_delta_reg <= major_delta_next;
            minor_delta_reg <= minor_delta_next;
            err_reg         <= err_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

// ===== design/line_point_stepper.sv =====
// top level of the line point stepper: configuration registers and wiring
// depends on lps_pkg, lps_front, lps_queue, lps_back
//
//  channel   signals                          direction  carries
//  command   cmd_valid / cmd_ready / cmd      in         load or step transaction
//  point     pt_valid / pt_ready / pt         out        one line point per step while drawing
//  config    cfg_wr_en / cfg_index / cfg_wdata in        image width and height
//
// one command per cycle while the queue is not full; a step's point is registered in turn by
// the queue write at acceptance, then the back end's state and output register
// a load reloads the back end's line state and gives no point
// a stalled point channel fills the four-entry queue, then cmd_ready drops
// reset clears queue, line state and output valid; image size returns to 1024 x 1024
module line_point_stepper (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cmd_valid,
    output logic                                cmd_ready,
    input  lps_pkg::cmd_t                       cmd,
    output logic                                pt_valid,
    input  logic                                pt_ready,
    output lps_pkg::point_t                     pt,
    input  logic                                cfg_wr_en,
    input  logic [lps_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [lps_pkg::DIM_BITS-1:0]        cfg_wdata
);
    import lps_pkg::*;

    cfg_t          cfg_reg, cfg_next;
    queue_status_t qstat;
    entry_t        push_entry, head;
    logic          push, pop;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  cfg_next.image_width  = cfg_wdata;
                CFG_IMAGE_HEIGHT: cfg_next.image_height = cfg_wdata;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width  <= DIM_RESET;
            cfg_reg.image_height <= DIM_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    lps_front u_front (
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .qstat     (qstat),
        .push      (push),
        .entry     (push_entry)
    );

    lps_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .entry (push_entry),
        .pop   (pop),
        .qstat (qstat),
        .head  (head)
    );

    lps_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .qstat    (qstat),
        .head     (head),
        .pop      (pop),
        .cfg      (cfg_reg),
        .pt_valid (pt_valid),
        .pt_ready (pt_ready),
        .pt       (pt)
    );

endmodule

// ===== design/lps_checker.sv =====
// port-level checks of the line point stepper, bound to the top level
// depends on lps_pkg and line_point_stepper_macros.svh
`include "line_point_stepper_macros.svh"

module lps_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cmd_valid,
    input  logic                                cmd_ready,
    input  lps_pkg::cmd_t                       cmd,
    input  logic                                pt_valid,
    input  logic                                pt_ready,
    input  lps_pkg::point_t                     pt,
    input  logic                                cfg_wr_en,
    input  logic [lps_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [lps_pkg::DIM_BITS-1:0]        cfg_wdata
);
    import lps_pkg::*;

    logic [DIM_BITS-1:0] width_reg, height_reg;
    logic                seen_load_reg;
    logic                inside_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= DIM_RESET;
            height_reg    <= DIM_RESET;
            seen_load_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en && (cfg_index == CFG_IMAGE_WIDTH))
            begin
                width_reg <= cfg_wdata;
            end
            if (cfg_wr_en && (cfg_index == CFG_IMAGE_HEIGHT))
            begin
                height_reg <= cfg_wdata;
            end
            if (cmd_valid && cmd_ready && (cmd.action == ACT_LOAD))
            begin
                seen_load_reg <= 1'b1;
            end
        end
    end

    assign inside_ok = !pt.point_x[COORD_BITS-1] && !pt.point_y[COORD_BITS-1]
                    && (CMP_BITS'($unsigned(pt.point_x)) < CMP_BITS'(width_reg))
                    && (CMP_BITS'($unsigned(pt.point_y)) < CMP_BITS'(height_reg));

    // stalled point holds
    `LPS_ASSERT_NEXT(a_pt_hold, pt_valid && !pt_ready, pt_valid && $stable(pt))
    // no point before any line was loaded
    `LPS_ASSERT_IMPL(a_pt_after_load, pt_valid, seen_load_reg)
    // inside flag agrees with the configured image size
    `LPS_ASSERT_IMPL(a_inside_bounds, pt_valid && pt.inside_res, inside_ok)
    // output channel comes out of reset empty
    `LPS_ASSERT_IMPL(a_reset_empty, $rose(rst_n), !pt_valid)

endmodule

bind line_point_stepper lps_checker u_lps_checker (.*);
